// File: hw/rtl/sfcp_pkg.sv
// sfcp_pkg: shared types, codes and tables of the scanf format conversion parser
// used by every module of the block and by the channel interfaces
package sfcp_pkg;

	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned WIDTH_W  = 20;
	localparam int unsigned LOW_W    = 58;
	localparam int unsigned HIGH_W   = 60;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned Q_DEPTH  = 4;
	localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W  = $clog2(Q_DEPTH + 1);

	localparam logic [WIDTH_W-1:0] WIDTH_CAP = WIDTH_W'(1000000);

	localparam logic [KIND_W-1:0] KIND_REC = 2'd0;
	localparam logic [KIND_W-1:0] KIND_OK  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BAD = 2'd2;

	localparam logic [CHAR_W-1:0] CH_PCT     = 8'h25;
	localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LBRACK  = 8'h5B;
	localparam logic [CHAR_W-1:0] CH_RBRACK  = 8'h5D;
	localparam logic [CHAR_W-1:0] CH_CARET   = 8'h5E;
	localparam logic [CHAR_W-1:0] CH_LOW_H   = 8'h68;
	localparam logic [CHAR_W-1:0] CH_LOW_L   = 8'h6C;
	localparam logic [CHAR_W-1:0] CH_LOW_J   = 8'h6A;
	localparam logic [CHAR_W-1:0] CH_LOW_Z   = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_LOW_T   = 8'h74;
	localparam logic [CHAR_W-1:0] CH_UP_L    = 8'h4C;
	localparam logic [CHAR_W-1:0] CH_LOW_Q   = 8'h71;
	localparam logic [CHAR_W-1:0] CH_LOW_D   = 8'h64;
	localparam logic [CHAR_W-1:0] CH_LOW_U   = 8'h75;
	localparam logic [CHAR_W-1:0] CH_LOW_X   = 8'h78;
	localparam logic [CHAR_W-1:0] CH_UP_X    = 8'h58;
	localparam logic [CHAR_W-1:0] CH_LOW_O   = 8'h6F;
	localparam logic [CHAR_W-1:0] CH_LOW_I   = 8'h69;

	localparam logic [WIDTH_W-1:0] DEC_MAX_W = WIDTH_W'(18);
	localparam logic [WIDTH_W-1:0] HEX_MAX_W = WIDTH_W'(15);
	localparam logic [WIDTH_W-1:0] OCT_MAX_W = WIDTH_W'(20);

	// one queued job: an optional conversion record and an optional end marker
	typedef struct packed {
		logic               rec_valid;
		logic               end_valid;
		logic               end_bad;
		logic               suppressed;
		logic [WIDTH_W-1:0] width;
		logic [CHAR_W-1:0]  conv;
	} entry_t;

	// 10^n - 1
	function automatic logic [HIGH_W-1:0] pow10_m1(input logic [4:0] n);
		logic [HIGH_W-1:0] r;
		case (n)
			5'd0:    r = 60'd0;
			5'd1:    r = 60'd9;
			5'd2:    r = 60'd99;
			5'd3:    r = 60'd999;
			5'd4:    r = 60'd9999;
			5'd5:    r = 60'd99999;
			5'd6:    r = 60'd999999;
			5'd7:    r = 60'd9999999;
			5'd8:    r = 60'd99999999;
			5'd9:    r = 60'd999999999;
			5'd10:   r = 60'd9999999999;
			5'd11:   r = 60'd99999999999;
			5'd12:   r = 60'd999999999999;
			5'd13:   r = 60'd9999999999999;
			5'd14:   r = 60'd99999999999999;
			5'd15:   r = 60'd999999999999999;
			5'd16:   r = 60'd9999999999999999;
			5'd17:   r = 60'd99999999999999999;
			5'd18:   r = 60'd999999999999999999;
			default: r = '0;
		endcase
		return r;
	endfunction

	// 2^n - 1 for n up to 60
	function automatic logic [HIGH_W-1:0] ones_mask(input logic [5:0] n);
		logic [6:0] sh;
		sh = 7'(HIGH_W) - {1'b0, n};
		return {HIGH_W{1'b1}} >> sh;
	endfunction

endpackage

// File: hw/rtl/sfcp_in_if.sv
// sfcp_in_if: character channel of the format parser, valid/ready handshake
// depends on sfcp_pkg
interface sfcp_in_if;
	import sfcp_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              last_char;

	modport source (output valid, character, last_char, input ready);
	modport sink (input valid, character, last_char, output ready);
endinterface

// File: hw/rtl/sfcp_out_if.sv
// sfcp_out_if: result channel of the format parser, valid/ready handshake
// depends on sfcp_pkg
interface sfcp_out_if;
	import sfcp_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic                     suppressed;
	logic [WIDTH_W-1:0]       field_width;
	logic [CHAR_W-1:0]        conversion_char;
	logic                     bound_valid;
	logic signed [LOW_W-1:0]  bound_low;
	logic [HIGH_W-1:0]        bound_high;
	logic                     last_result;

	modport source (output valid, kind, suppressed, field_width, conversion_char,
		bound_valid, bound_low, bound_high, last_result, input ready);
	modport sink (input valid, kind, suppressed, field_width, conversion_char,
		bound_valid, bound_low, bound_high, last_result, output ready);
endinterface

// File: hw/rtl/sfcp_front.sv
// sfcp_front: accepts format characters, runs the conversion phase machine
// and pushes record and end jobs into the queue; depends on sfcp_pkg, sfcp_in_if
module sfcp_front (
	input  logic             clk,
	input  logic             arst_n,
	sfcp_in_if.sink          chars,
	input  logic             q_full,
	output logic             push,
	output sfcp_pkg::entry_t push_data
);
	import sfcp_pkg::*;

	typedef enum logic [2:0] {
		PH_LIT       = 3'd0,
		PH_PCT       = 3'd1,
		PH_WIDTH     = 3'd2,
		PH_MODS      = 3'd3,
		PH_SET_OPEN  = 3'd4,
		PH_SET_CARET = 3'd5,
		PH_SET_BODY  = 3'd6
	} phase_t;

	phase_t             phase_q, phase_nxt;
	logic               sup_q, sup_nxt;
	logic [WIDTH_W-1:0] width_q, width_nxt;
	logic               accept, digit, modifier, rec, is_conv;
	logic [CHAR_W-1:0]  ch, rec_conv;
	logic [23:0]        width_sum;

	assign ch       = chars.character;
	assign accept   = chars.valid && chars.ready;
	assign chars.ready = !q_full;
	assign digit    = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign modifier = (ch == CH_LOW_H) || (ch == CH_LOW_L) || (ch == CH_LOW_J) ||
		(ch == CH_LOW_Z) || (ch == CH_LOW_T) || (ch == CH_UP_L) || (ch == CH_LOW_Q);
	assign width_sum = {1'b0, width_q, 3'b000} + {3'b000, width_q, 1'b0} +
		24'(ch - CH_ZERO);

	always_comb begin
		phase_nxt = phase_q;
		sup_nxt   = sup_q;
		width_nxt = width_q;
		is_conv   = 1'b0;
		rec       = 1'b0;
		rec_conv  = ch;
		unique case (phase_q)
			PH_PCT: begin
				if (ch == CH_PCT) begin
					phase_nxt = PH_LIT;
				end else if (ch == CH_STAR) begin
					sup_nxt   = 1'b1;
					phase_nxt = PH_WIDTH;
				end else if (digit) begin
					phase_nxt = PH_WIDTH;
				end else if (modifier) begin
					phase_nxt = PH_MODS;
				end else begin
					is_conv = 1'b1;
				end
			end
			PH_WIDTH: begin
				if (modifier) begin
					phase_nxt = PH_MODS;
				end else if (!digit) begin
					is_conv = 1'b1;
				end
			end
			PH_MODS: begin
				is_conv = !modifier;
			end
			PH_SET_OPEN: begin
				phase_nxt = (ch == CH_CARET) ? PH_SET_CARET : PH_SET_BODY;
			end
			PH_SET_CARET: begin
				phase_nxt = PH_SET_BODY;
			end
			PH_SET_BODY: begin
				if (ch == CH_RBRACK) begin
					rec       = 1'b1;
					rec_conv  = CH_LBRACK;
					phase_nxt = PH_LIT;
				end
			end
			default: begin
				if (ch == CH_PCT) begin
					sup_nxt   = 1'b0;
					width_nxt = '0;
					phase_nxt = PH_PCT;
				end else begin
					phase_nxt = PH_LIT;
				end
			end
		endcase
		// width digits
		if (digit && (phase_q == PH_PCT || phase_q == PH_WIDTH)) begin
			width_nxt = (width_sum > 24'(WIDTH_CAP)) ? WIDTH_CAP : width_sum[WIDTH_W-1:0];
		end
		if (is_conv) begin
			if (ch == CH_LBRACK) begin
				phase_nxt = PH_SET_OPEN;
			end else begin
				rec       = 1'b1;
				phase_nxt = PH_LIT;
			end
		end
		push_data.rec_valid  = rec;
		push_data.end_valid  = chars.last_char;
		push_data.end_bad    = (phase_nxt != PH_LIT);
		push_data.suppressed = sup_q;
		push_data.width      = width_q;
		push_data.conv       = rec_conv;
		push = accept && (rec || chars.last_char);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LIT;
			sup_q   <= 1'b0;
			width_q <= '0;
		end else if (accept) begin
			if (chars.last_char) begin
				phase_q <= PH_LIT;
				sup_q   <= 1'b0;
				width_q <= '0;
			end else begin
				phase_q <= phase_nxt;
				sup_q   <= sup_nxt;
				width_q <= width_nxt;
			end
		end
	end

endmodule

// File: hw/rtl/sfcp_queue.sv
// sfcp_queue: short job queue between the parser front and the result back end
// depends on sfcp_pkg
module sfcp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sfcp_pkg::entry_t push_data,
	input  logic             pop,
	output logic             full,
	output logic             not_empty,
	output sfcp_pkg::entry_t head
);
	import sfcp_pkg::*;

	entry_t             slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign full      = (count_q == Q_CNT_W'(Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: hw/rtl/sfcp_back.sv
// sfcp_back: drains queued jobs, derives the width bound and drives the
// registered result channel; depends on sfcp_pkg, sfcp_out_if
module sfcp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             not_empty,
	input  sfcp_pkg::entry_t head,
	output logic             pop,
	sfcp_out_if.source       records
);
	import sfcp_pkg::*;

	logic                    out_valid_q, rec_done_q;
	logic                    take, emit_end;
	logic [KIND_W-1:0]       kind_q;
	logic                    sup_q, bvalid_q, last_q;
	logic [WIDTH_W-1:0]      width_q;
	logic [CHAR_W-1:0]       conv_q;
	logic signed [LOW_W-1:0] low_q;
	logic [HIGH_W-1:0]       high_q;
	logic                    bvalid;
	logic [HIGH_W-1:0]       hi, lo_mag;
	logic [4:0]              ws, ws_m1;
	logic [5:0]              hex_bits, hex_bits_m1, oct_bits;

	assign take     = not_empty && (!out_valid_q || records.ready);
	assign emit_end = !head.rec_valid || rec_done_q;
	assign pop      = take && (emit_end || !head.end_valid);

	assign ws          = head.width[4:0];
	assign ws_m1       = ws - 5'd1;
	assign hex_bits    = {ws[3:0], 2'b00};
	assign hex_bits_m1 = {ws_m1[3:0], 2'b00};
	assign oct_bits    = {ws, 1'b0} + {1'b0, ws};

	always_comb begin
		bvalid = 1'b0;
		hi     = '0;
		lo_mag = '0;
		if (head.width != '0) begin
			case (head.conv)
				CH_LOW_D, CH_LOW_U: begin
					if (head.width <= DEC_MAX_W) begin
						bvalid = 1'b1;
						hi     = pow10_m1(ws);
						if (head.conv == CH_LOW_D) begin
							lo_mag = pow10_m1(ws_m1);
						end
					end
				end
				CH_LOW_X, CH_UP_X: begin
					if (head.width <= HEX_MAX_W) begin
						bvalid = 1'b1;
						hi     = ones_mask(hex_bits);
					end
				end
				CH_LOW_O: begin
					if (head.width <= OCT_MAX_W) begin
						bvalid = 1'b1;
						hi     = ones_mask(oct_bits);
					end
				end
				CH_LOW_I: begin
					if (head.width <= HEX_MAX_W) begin
						bvalid = 1'b1;
						hi     = ones_mask(hex_bits);
						lo_mag = ones_mask(hex_bits_m1);
					end
				end
				default: begin
					bvalid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rec_done_q  <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
				rec_done_q  <= !emit_end && head.end_valid;
			end else if (records.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (emit_end) begin
				kind_q   <= head.end_bad ? KIND_BAD : KIND_OK;
				sup_q    <= 1'b0;
				width_q  <= '0;
				conv_q   <= '0;
				bvalid_q <= 1'b0;
				low_q    <= '0;
				high_q   <= '0;
				last_q   <= 1'b1;
			end else begin
				kind_q   <= KIND_REC;
				sup_q    <= head.suppressed;
				width_q  <= head.width;
				conv_q   <= head.conv;
				bvalid_q <= bvalid;
				low_q    <= LOW_W'(0) - lo_mag[LOW_W-1:0];
				high_q   <= hi;
				last_q   <= !head.end_valid;
			end
		end
	end

	assign records.valid           = out_valid_q;
	assign records.kind            = kind_q;
	assign records.suppressed      = sup_q;
	assign records.field_width     = width_q;
	assign records.conversion_char = conv_q;
	assign records.bound_valid     = bvalid_q;
	assign records.bound_low       = low_q;
	assign records.bound_high      = high_q;
	assign records.last_result     = last_q;

`ifndef ASSERT_OFF
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind_q != KIND_REC) |-> last_q)
		else $error("end result not marked last");
	a_bound_only_rec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && bvalid_q |-> (kind_q == KIND_REC) && (width_q != '0))
		else $error("bound on a result without width");
	a_split_pending: assert property (@(posedge clk) disable iff (!arst_n)
		rec_done_q |-> not_empty && head.rec_valid && head.end_valid)
		else $error("split job lost its queue entry");
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !records.ready |=> out_valid_q && $stable(kind_q) && $stable(last_q))
		else $error("stalled result changed");
`endif

endmodule

// File: hw/rtl/scanf_format_conversion_parser.sv
// scanf_format_conversion_parser: one format character per cycle in, one result per cycle out
// result path: the job queue, then the result register, which holds while records.ready is low
// throughput: one character per cycle; a character that ends a conversion and the string
//   yields two results, the record first; input stalls only while the 4-entry queue is full
// reset: arst_n clears the phase machine, the job queue and the result valid flag
// depends on sfcp_pkg, sfcp_in_if, sfcp_out_if, sfcp_front, sfcp_queue, sfcp_back
module scanf_format_conversion_parser (
	input  logic       clk,
	input  logic       arst_n,
	sfcp_in_if.sink    chars,
	sfcp_out_if.source records
);
	import sfcp_pkg::*;

	entry_t push_data, head;
	logic   push, pop, q_full, q_not_empty;

	sfcp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.chars     (chars),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	sfcp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head)
	);

	sfcp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (q_not_empty),
		.head      (head),
		.pop       (pop),
		.records   (records)
	);

endmodule
